// ----- rtl/rqc_pkg.sv -----
// ----------------------------------------------------------------------------
// rqc_pkg
// Types and widths shared by the conic point pipeline and its checker.
// ----------------------------------------------------------------------------
package rqc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int STEP_BITS   = 6;
  localparam int MAX_STEPS   = 63;
  localparam int STEP_RESET  = 16;

  // bernstein terms stay below 2^12 for n <= 63
  localparam int BERN_BITS = 2 * STEP_BITS;
  // weighted terms, unsigned
  localparam int TERM_BITS = BERN_BITS + WEIGHT_BITS;
  // weighted term times coordinate, signed
  localparam int PROD_BITS = TERM_BITS + COORD_BITS + 1;
  // numerator sum, signed, with room for doubling and bias
  localparam int NUM_BITS  = PROD_BITS + 3;
  // denominator sum of three terms
  localparam int DEN_BITS  = TERM_BITS + 2;
  // doubled denominator (divisor)
  localparam int DIV_BITS  = DEN_BITS + 1;
  // quotient is biased by half the coordinate range so it is never negative
  localparam int QUOT_BITS = COORD_BITS;
  // biased dividend stays below divisor * 2^QUOT_BITS
  localparam int REM_BITS  = DIV_BITS + QUOT_BITS - 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  mid_x;
    logic signed [COORD_BITS-1:0]  mid_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic        [WEIGHT_BITS-1:0] weight_start;
    logic        [WEIGHT_BITS-1:0] weight_mid;
    logic        [WEIGHT_BITS-1:0] weight_end;
    logic                          begin_with_move;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         pen_down;
    logic                         last_point;
    logic                         zero_weight_sum;
  } out_word_t;

  typedef struct packed {
    logic pen_down;
    logic last_point;
  } pt_flags_t;

endpackage

// ----- rtl/rational_quadratic_curve_points.sv -----
// ----------------------------------------------------------------------------
// rational_quadratic_curve_points
// Rational quadratic bezier segment to plotter points, one point per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel  signals                        word
//  in       in_valid / in_ready            in_data  : one segment
//  out      out_valid / out_ready          out_data : one point
//  cfg      cfg_valid / cfg_ready          cfg_data : step count
//
//  a segment gives n+1 points (n when the move is skipped), one per cycle
//  unless the output stalls; the next segment is taken in the cycle the last
//  point issues, so segments follow one another without a gap.
//  from issue to out_data a point passes 4 arithmetic stages,
//  16 restoring divide stages (one quotient bit each), the output register.
//  a stalled output freezes the whole pipeline; nothing is dropped.
//  synchronous reset clears valid bits and the generator, and sets the step count to 16.
module rational_quadratic_curve_points #(
  parameter int MAX_STEPS = rqc_pkg::MAX_STEPS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rqc_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rqc_pkg::out_word_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rqc_pkg::STEP_BITS-1:0] cfg_data
);
  import rqc_pkg::*;

  localparam int NDIV = QUOT_BITS;

  logic [STEP_BITS-1:0] step_count;
  logic [STEP_BITS-1:0] n_eff;

  logic                 busy;
  logic [STEP_BITS-1:0] cnt;
  logic [STEP_BITS-1:0] n_cur;
  in_word_t             seg;

  logic adv;
  logic issue;
  logic last_issue;
  logic accept;

  // stage 1: bernstein terms
  logic                 v1;
  logic [BERN_BITS-1:0] b0, b1, b2;
  in_word_t             seg1;
  pt_flags_t            f1;
  logic [STEP_BITS-1:0] n_left;

  // stage 2: weighted terms
  logic                 v2;
  logic [TERM_BITS-1:0] t0, t1, t2;
  in_word_t             seg2;
  pt_flags_t            f2;

  // stage 3: products
  logic                        v3;
  logic signed [PROD_BITS-1:0] px0, px1, px2, py0, py1, py2;
  logic [DEN_BITS-1:0]         den3;
  pt_flags_t                   f3;

  // stage 4: biased dividends
  logic                        v4;
  logic [REM_BITS-1:0]         ax4, ay4;
  logic [DIV_BITS-1:0]         dv4;
  logic                        z4;
  pt_flags_t                   f4;
  logic signed [NUM_BITS-1:0]  numx, numy, biasx, biasy;

  // divide stages
  logic                 dvld [NDIV];
  logic [REM_BITS-1:0]  rx   [NDIV];
  logic [REM_BITS-1:0]  ry   [NDIV];
  logic [QUOT_BITS-1:0] qx   [NDIV];
  logic [QUOT_BITS-1:0] qy   [NDIV];
  logic [DIV_BITS-1:0]  dd   [NDIV];
  logic                 dz   [NDIV];
  pt_flags_t            df   [NDIV];

  assign cfg_ready = 1'b1;
  assign n_eff = (step_count == '0) ? STEP_BITS'(1) :
                 (step_count > STEP_BITS'(MAX_STEPS)) ? STEP_BITS'(MAX_STEPS) : step_count;

  assign adv        = !(out_valid && !out_ready);
  assign issue      = busy && adv;
  assign last_issue = (cnt == n_cur);
  assign in_ready   = adv && (!busy || last_issue);
  assign accept     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= STEP_BITS'(STEP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      step_count <= cfg_data;
    end
  end

  // point generator
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= in_data.begin_with_move ? '0 : STEP_BITS'(1);
    end else if (issue) begin
      if (last_issue) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + STEP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg   <= in_data;
      n_cur <= n_eff;
    end
  end

  assign n_left = n_cur - cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0            <= BERN_BITS'(n_left) * BERN_BITS'(n_left);
      b1            <= BERN_BITS'({BERN_BITS'(cnt) * BERN_BITS'(n_left), 1'b0});
      b2            <= BERN_BITS'(cnt) * BERN_BITS'(cnt);
      seg1          <= seg;
      f1.pen_down   <= (cnt != '0);
      f1.last_point <= last_issue;

      t0   <= TERM_BITS'(b0) * TERM_BITS'(seg1.weight_start);
      t1   <= TERM_BITS'(b1) * TERM_BITS'(seg1.weight_mid);
      t2   <= TERM_BITS'(b2) * TERM_BITS'(seg1.weight_end);
      seg2 <= seg1;
      f2   <= f1;

      px0  <= $signed(PROD_BITS'(t0)) * PROD_BITS'(seg2.start_x);
      px1  <= $signed(PROD_BITS'(t1)) * PROD_BITS'(seg2.mid_x);
      px2  <= $signed(PROD_BITS'(t2)) * PROD_BITS'(seg2.end_x);
      py0  <= $signed(PROD_BITS'(t0)) * PROD_BITS'(seg2.start_y);
      py1  <= $signed(PROD_BITS'(t1)) * PROD_BITS'(seg2.mid_y);
      py2  <= $signed(PROD_BITS'(t2)) * PROD_BITS'(seg2.end_y);
      den3 <= DEN_BITS'(t0) + DEN_BITS'(t1) + DEN_BITS'(t2);
      f3   <= f2;
    end
  end

  // floor(num/den + 1/2) + 2^15 = floor((2 num + den + 2^16 den) / (2 den));
  // weights are nonnegative so the point is a convex mix and never saturates
  assign numx  = NUM_BITS'(px0) + NUM_BITS'(px1) + NUM_BITS'(px2);
  assign numy  = NUM_BITS'(py0) + NUM_BITS'(py1) + NUM_BITS'(py2);
  assign biasx = (numx <<< 1) + $signed(NUM_BITS'(den3))
               + $signed(NUM_BITS'(den3) << QUOT_BITS);
  assign biasy = (numy <<< 1) + $signed(NUM_BITS'(den3))
               + $signed(NUM_BITS'(den3) << QUOT_BITS);

  always_ff @(posedge clk) begin
    if (adv) begin
      ax4 <= biasx[REM_BITS-1:0];
      ay4 <= biasy[REM_BITS-1:0];
      dv4 <= {den3, 1'b0};
      z4  <= (den3 == '0);
      f4  <= f3;
    end
  end

  // restoring divide, most significant quotient bit first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NDIV; j++) begin
        dvld[j] <= 1'b0;
      end
    end else if (adv) begin
      dvld[0] <= v4;
      for (int j = 1; j < NDIV; j++) begin
        dvld[j] <= dvld[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [REM_BITS-1:0] sh;
    if (adv) begin
      sh = REM_BITS'(dv4) << (NDIV - 1);
      rx[0] <= (ax4 >= sh) ? ax4 - sh : ax4;
      ry[0] <= (ay4 >= sh) ? ay4 - sh : ay4;
      qx[0] <= {(ax4 >= sh), {(QUOT_BITS-1){1'b0}}};
      qy[0] <= {(ay4 >= sh), {(QUOT_BITS-1){1'b0}}};
      dd[0] <= dv4;
      dz[0] <= z4;
      df[0] <= f4;
      for (int j = 1; j < NDIV; j++) begin
        sh = REM_BITS'(dd[j-1]) << (NDIV - 1 - j);
        rx[j] <= (rx[j-1] >= sh) ? rx[j-1] - sh : rx[j-1];
        ry[j] <= (ry[j-1] >= sh) ? ry[j-1] - sh : ry[j-1];
        qx[j] <= qx[j-1] | ((rx[j-1] >= sh) ? QUOT_BITS'(1) << (NDIV - 1 - j) : '0);
        qy[j] <= qy[j-1] | ((ry[j-1] >= sh) ? QUOT_BITS'(1) << (NDIV - 1 - j) : '0);
        dd[j] <= dd[j-1];
        dz[j] <= dz[j-1];
        df[j] <= df[j-1];
      end
    end
  end

  // output register; removing the bias is a flip of the top bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dvld[NDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.point_x <= dz[NDIV-1] ? '0 :
        $signed({~qx[NDIV-1][QUOT_BITS-1], qx[NDIV-1][QUOT_BITS-2:0]});
      out_data.point_y <= dz[NDIV-1] ? '0 :
        $signed({~qy[NDIV-1][QUOT_BITS-1], qy[NDIV-1][QUOT_BITS-2:0]});
      out_data.pen_down        <= df[NDIV-1].pen_down;
      out_data.last_point      <= df[NDIV-1].last_point;
      out_data.zero_weight_sum <= dz[NDIV-1];
    end
  end

endmodule

// ----- rtl/rqc_checker.sv -----
// ----------------------------------------------------------------------------
// rqc_checker
// Port-level checks for the conic point pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rqc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rqc_pkg::out_word_t out_data
);
  import rqc_pkg::*;

  // a held word does not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // zero denominator forces the origin
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_weight_sum |->
      out_data.point_x == '0 && out_data.point_y == '0)
    else $error("zero weight sum with nonzero point");

  // the move point is never the last one since n is at least one
  a_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pen_down |-> !out_data.last_point)
    else $error("move word flagged as last point");

  // a stalled output holds the input side too
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input ready under output stall");

endmodule

bind rational_quadratic_curve_points rqc_checker u_rqc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
